@@ rtl/cxys8_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cxys8_pkg
// shared types, matrix coefficients and encoding tables for the xy to srgb8
// colour converter
// ----------------------------------------------------------------------------
package cxys8_pkg;

	// fractional bits of the normalised channel ratio
	localparam int RATIO_FRAC_BITS = 16;
	localparam int RATIO_W = RATIO_FRAC_BITS + 1;

	localparam int COORD_W = 16;
	localparam int CRD_W   = 18;    // signed x, y, 1-x-y
	localparam int COEF_W  = 26;    // signed coefficient, scaled by 10^7
	localparam int PROD_W  = 44;
	localparam int SUM_W   = 46;
	localparam int CH_W    = 43;    // clamped linear channel

	localparam int FRONT_LAT = 4;   // front stages holding requests in flight
	localparam int QDEPTH    = 8;
	localparam int QPTR_W    = $clog2(QDEPTH);

	localparam int LIN_CODES = 11;  // codes reachable on the linear segment
	localparam int LIN_W     = 4;

	typedef struct packed {
		logic [COORD_W-1:0] chroma_x;
		logic [COORD_W-1:0] chroma_y;
	} chroma_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} colour_t;

	typedef logic [CH_W-1:0] chan_t;

	// classified request handed from front to back
	typedef struct packed {
		chan_t [2:0] chan;
		chan_t       peak;
		logic        black;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic hold;
	} qstat_t;

	// xyz to linear srgb, rows r, g, b; columns x, y, z
	localparam logic signed [COEF_W-1:0] MTX [3][3] = '{
		'{ 26'sd32404542, -26'sd15371385, -26'sd4985314 },
		'{-26'sd9692660,   26'sd18760108,  26'sd415560  },
		'{ 26'sd556434,   -26'sd2040259,   26'sd10572252}
	};

	typedef logic [255:0][RATIO_W-1:0]        curve_tab_t;
	typedef logic [LIN_CODES:1][RATIO_W-1:0]  lin_tab_t;

	// exact test u^5 * 53805^12 >= (200k + 2705)^12 * 2^(5F)
	function automatic logic curve_reaches(input logic [RATIO_W-1:0] u, input int k);
		logic [383:0] lhs;
		logic [383:0] rhs;
		int i;
		lhs = 384'd1;
		rhs = 384'd1;
		for (i = 0; i < 5; i++) begin
			lhs = lhs * 384'(u);
			rhs = rhs << RATIO_FRAC_BITS;
		end
		for (i = 0; i < 12; i++) begin
			lhs = lhs * 384'd53805;
			rhs = rhs * 384'(200 * k + 2705);
		end
		return lhs >= rhs;
	endfunction

	// smallest ratio that reaches code k
	function automatic logic [RATIO_W-1:0] curve_thr(input int k);
		logic [RATIO_W:0] lo;
		logic [RATIO_W:0] hi;
		logic [RATIO_W:0] mid;
		int it;
		lo = '0;
		hi = (RATIO_W + 1)'(1) << RATIO_FRAC_BITS;
		for (it = 0; it < RATIO_W + 1; it++) begin
			if (lo < hi) begin
				mid = (lo + hi) >> 1;
				if (curve_reaches(mid[RATIO_W-1:0], k))
					hi = mid;
				else
					lo = mid + 1'b1;
			end
		end
		return lo[RATIO_W-1:0];
	endfunction

	function automatic curve_tab_t build_curve_tab();
		curve_tab_t t;
		int k;
		t = '0;
		for (k = 1; k < 256; k++)
			t[k] = curve_thr(k);
		return t;
	endfunction

	// smallest ratio whose linear code reaches k
	function automatic lin_tab_t build_lin_tab();
		lin_tab_t t;
		longint num;
		int k;
		for (k = 1; k <= LIN_CODES; k++) begin
			num = (longint'(10 * k - 5) << RATIO_FRAC_BITS) + 64'sd32945;
			t[k] = RATIO_W'(num / 64'sd32946);
		end
		return t;
	endfunction

	localparam curve_tab_t CURVE_THR = build_curve_tab();
	localparam lin_tab_t   LIN_THR   = build_lin_tab();
	localparam logic [RATIO_W-1:0] LIN_LIMIT =
		RATIO_W'((64'd31308 << RATIO_FRAC_BITS) / 64'd10000000);

endpackage
`default_nettype wire

@@ rtl/chromaticity_xy_to_srgb8.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chromaticity_xy_to_srgb8
// cie xy chromaticity to a peak-normalised 8-bit srgb colour
// ----------------------------------------------------------------------------
// A request (chroma_x, chroma_y, both unsigned q0.16) is taken on any clock
// edge with start high and busy low, one per clock. Each colour appears on
// the colour port for exactly one cycle with done high, after the front,
// the queue, the restoring divider, one quotient bit per stage, and the
// eight-stage search of the srgb curve table. The receiver cannot stall
// the block, and busy stays low in normal use since the back end drains
// the queue every cycle. y of zero, or a colour with no positive linear
// channel, gives black.
// ----------------------------------------------------------------------------
module chromaticity_xy_to_srgb8 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cxys8_pkg::chroma_t  chroma,
	output logic               done,
	output cxys8_pkg::colour_t colour
);
	import cxys8_pkg::*;

	logic   take;
	logic   push;
	logic   pop;
	job_t   front_job;
	job_t   back_job;
	qstat_t qstat;

	// request accepted
	assign take = start && !busy;
	// stop taking requests only when the queue could not absorb the front
	assign busy = qstat.hold;
	// back end never stalls, so it takes whatever waits at the head
	assign pop  = !qstat.empty;

	// front: matrix, clamp, peak and black detection
	cxys8_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.chroma (chroma),
		.push   (push),
		.job    (front_job)
	);

	// decoupling queue
	cxys8_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (front_job),
		.pop    (pop),
		.rd_job (back_job),
		.stat   (qstat)
	);

	// back: normalise each channel and apply the transfer curve
	cxys8_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (pop),
		.job    (back_job),
		.done   (done),
		.colour (colour)
	);

endmodule
`default_nettype wire

@@ rtl/cxys8_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cxys8_front
// takes requests, applies the matrix, clamps and finds the peak channel
// ----------------------------------------------------------------------------
module cxys8_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  cxys8_pkg::chroma_t chroma,
	output logic              push,
	output cxys8_pkg::job_t   job
);
	import cxys8_pkg::*;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic [COORD_W-1:0]   x_s1, y_s1;
	logic                 blk_s1, blk_s2, blk_s3;
	logic signed [CRD_W-1:0]  crd [3];
	logic signed [PROD_W-1:0] prod_s2 [3][3];
	chan_t                ch_s3 [3];
	logic signed [SUM_W-1:0]  sum [3];
	job_t                 job_s4;
	chan_t                pk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// z may go negative when x + y passes one
	always_comb begin
		crd[0] = $signed({2'b00, x_s1});
		crd[1] = $signed({2'b00, y_s1});
		crd[2] = CRD_W'(18'sd65536 - crd[0] - crd[1]);
	end

	always_comb begin
		for (int c = 0; c < 3; c++)
			sum[c] = SUM_W'(prod_s2[c][0]) + SUM_W'(prod_s2[c][1]) + SUM_W'(prod_s2[c][2]);
	end

	always_comb begin
		pk = ch_s3[0];
		if (ch_s3[1] > pk)
			pk = ch_s3[1];
		if (ch_s3[2] > pk)
			pk = ch_s3[2];
	end

	always_ff @(posedge clk) begin
		x_s1   <= chroma.chroma_x;
		y_s1   <= chroma.chroma_y;
		blk_s1 <= (chroma.chroma_y == '0);
		blk_s2 <= blk_s1;
		for (int c = 0; c < 3; c++)
			for (int j = 0; j < 3; j++)
				prod_s2[c][j] <= PROD_W'(MTX[c][j]) * PROD_W'(crd[j]);
		blk_s3 <= blk_s2;
		for (int c = 0; c < 3; c++)
			ch_s3[c] <= (!sum[c][SUM_W-1] && (sum[c] != '0)) ? sum[c][CH_W-1:0] : '0;
		job_s4.chan[0] <= ch_s3[0];
		job_s4.chan[1] <= ch_s3[1];
		job_s4.chan[2] <= ch_s3[2];
		job_s4.peak    <= pk;
		job_s4.black   <= blk_s3 || (pk == '0);
	end

	assign push = vld_s4;
	assign job  = job_s4;

endmodule
`default_nettype wire

@@ rtl/cxys8_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cxys8_queue
// short request queue between front and back
// ----------------------------------------------------------------------------
module cxys8_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cxys8_pkg::job_t   wr_job,
	input  logic              pop,
	output cxys8_pkg::job_t   rd_job,
	output cxys8_pkg::qstat_t stat
);
	import cxys8_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
		end
	end

	assign rd_job     = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (QPTR_W + 1)'(QDEPTH));
	// leave room for every request still inside the front
	assign stat.hold  = (count_q >= (QPTR_W + 1)'(QDEPTH - FRONT_LAT));

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full && !pop))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && stat.empty))
		else $error("queue underflow");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count out of step");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W + 1)'(1))
		else $error("queue backs up although back never stalls");

endmodule
`default_nettype wire

@@ rtl/cxys8_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cxys8_back
// divides each channel by the peak and encodes it with the srgb curve
// ----------------------------------------------------------------------------
module cxys8_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  cxys8_pkg::job_t   job,
	output logic              done,
	output cxys8_pkg::colour_t colour
);
	import cxys8_pkg::*;

	localparam int ND = RATIO_FRAC_BITS + 1;  // divider stages

	// divider stages
	logic                vld_sd [ND];
	chan_t               rem_sd [ND][3];
	logic [RATIO_W-1:0]  quo_sd [ND][3];
	chan_t               peak_sd [ND];
	logic                blk_sd [ND];

	// rounding stage
	logic                vld_sr;
	logic [RATIO_W-1:0]  ratio_sr [3];
	logic                blk_sr;

	// encoder stages, one code bit each
	logic [8:1]          vld_se;
	logic [RATIO_W-1:0]  ratio_se [9][3];
	logic [7:0]          code_se [9][3];
	logic                lin_se [9][3];
	logic [LIN_W-1:0]    lcode_se [9][3];
	logic                blk_se [9];

	logic                done_q;
	colour_t             colour_q;

	// first divider step: integer bit, only set when the channel is the peak
	always_ff @(posedge clk) begin
		peak_sd[0] <= job.peak;
		blk_sd[0]  <= job.black;
		for (int c = 0; c < 3; c++) begin
			quo_sd[0][c] <= RATIO_W'(job.chan[c] >= job.peak);
			rem_sd[0][c] <= (job.chan[c] >= job.peak) ? job.chan[c] - job.peak : job.chan[c];
		end
	end

	genvar i, c;
	generate
		for (i = 1; i < ND; i++) begin : g_div
			for (c = 0; c < 3; c++) begin : g_lane
				logic [CH_W:0] twice;
				logic          ge;
				assign twice = {rem_sd[i-1][c], 1'b0};
				assign ge    = (twice >= {1'b0, peak_sd[i-1]});
				always_ff @(posedge clk) begin
					rem_sd[i][c] <= CH_W'(ge ? twice - {1'b0, peak_sd[i-1]} : twice);
					quo_sd[i][c] <= {quo_sd[i-1][c][RATIO_W-2:0], ge};
				end
			end
			always_ff @(posedge clk) begin
				peak_sd[i] <= peak_sd[i-1];
				blk_sd[i]  <= blk_sd[i-1];
			end
		end
	endgenerate

	// round half up
	always_ff @(posedge clk) begin
		blk_sr <= blk_sd[ND-1];
		for (int k = 0; k < 3; k++)
			ratio_sr[k] <= quo_sd[ND-1][k] +
				RATIO_W'({rem_sd[ND-1][k], 1'b0} >= {1'b0, peak_sd[ND-1]});
	end

	always_comb begin
		blk_se[0] = blk_sr;
		for (int k = 0; k < 3; k++) begin
			ratio_se[0][k] = ratio_sr[k];
			code_se[0][k]  = '0;
			lin_se[0][k]   = 1'b0;
			lcode_se[0][k] = '0;
		end
	end

	generate
		for (i = 1; i < 9; i++) begin : g_enc
			for (c = 0; c < 3; c++) begin : g_lane
				logic [7:0]       trial;
				logic             lin;
				logic [LIN_W-1:0] lcode;
				assign trial = code_se[i-1][c] | (8'd1 << (8 - i));
				always_comb begin
					if (i == 1) begin
						lin   = (ratio_se[i-1][c] <= LIN_LIMIT);
						lcode = '0;
						for (int k = 1; k <= LIN_CODES; k++)
							if (ratio_se[i-1][c] >= LIN_THR[k])
								lcode = LIN_W'(k);
					end else begin
						lin   = lin_se[i-1][c];
						lcode = lcode_se[i-1][c];
					end
				end
				always_ff @(posedge clk) begin
					ratio_se[i][c] <= ratio_se[i-1][c];
					code_se[i][c]  <= (ratio_se[i-1][c] >= CURVE_THR[trial]) ?
						trial : code_se[i-1][c];
					lin_se[i][c]   <= lin;
					lcode_se[i][c] <= lcode;
				end
			end
			always_ff @(posedge clk) begin
				blk_se[i] <= blk_se[i-1];
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		colour_q.red   <= blk_se[8] ? 8'd0 : lin_se[8][0] ? 8'(lcode_se[8][0]) : code_se[8][0];
		colour_q.green <= blk_se[8] ? 8'd0 : lin_se[8][1] ? 8'(lcode_se[8][1]) : code_se[8][1];
		colour_q.blue  <= blk_se[8] ? 8'd0 : lin_se[8][2] ? 8'(lcode_se[8][2]) : code_se[8][2];
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ND; k++)
				vld_sd[k] <= 1'b0;
			vld_sr <= 1'b0;
			vld_se <= '0;
			done_q <= 1'b0;
		end else begin
			vld_sd[0] <= go;
			for (int k = 1; k < ND; k++)
				vld_sd[k] <= vld_sd[k-1];
			vld_sr <= vld_sd[ND-1];
			vld_se <= {vld_se[7:1], vld_sr};
			done_q <= vld_se[8];
		end
	end

	assign done   = done_q;
	assign colour = colour_q;

endmodule
`default_nettype wire

@@ tb/chroma_colour_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chroma_colour_checker
// predicts the srgb8 colour of every accepted request and compares it with
// the colour the converter hands back, oldest first
// ----------------------------------------------------------------------------
module chroma_colour_checker
	import cxys8_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  chroma_t chroma,
	input  logic    done,
	input  colour_t colour,
	output int      fail_count,
	output int      colours_pending,
	output int      colours_checked
);

	colour_t colour_due [$];

	// exact power-curve threshold test for code k
	function automatic logic curve_hit(input logic [63:0] r, input int k);
		logic [383:0] lhs;
		logic [383:0] rhs;
		lhs = 384'd1;
		rhs = 384'd1;
		repeat (5) begin
			lhs = lhs * 384'(r);
			rhs = rhs << RATIO_FRAC_BITS;
		end
		repeat (12) begin
			lhs = lhs * 384'd53805;
			rhs = rhs * 384'(200 * k + 2705);
		end
		return lhs >= rhs;
	endfunction

	function automatic logic [7:0] srgb_code(input logic [63:0] r);
		logic [63:0] unit;
		int lo;
		int hi;
		int mid;
		unit = 64'd1 << RATIO_FRAC_BITS;
		if (r == 0)
			return 8'd0;
		if (r >= unit)
			return 8'd255;
		if (r * 64'd10000000 <= 64'd31308 * unit)
			return 8'((r * 64'd32946 + 64'd5 * unit) / (64'd10 * unit));
		lo = 0;
		hi = 255;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (curve_hit(r, mid))
				lo = mid;
			else
				hi = mid - 1;
		end
		return 8'(lo);
	endfunction

	// channel over peak, rounded half up, q1.F
	function automatic logic [63:0] peak_ratio(input logic [63:0] ch, input logic [63:0] pk);
		logic [63:0] q;
		logic [63:0] rem;
		q = (ch >= pk) ? 64'd1 : 64'd0;
		rem = ch - q * pk;
		repeat (RATIO_FRAC_BITS) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= pk) begin
				rem = rem - pk;
				q[0] = 1'b1;
			end
		end
		if (rem * 2 >= pk)
			q = q + 1;
		return q;
	endfunction

	function automatic colour_t predict_colour(input chroma_t c);
		longint cx;
		longint cy;
		longint cz;
		longint lin [3];
		logic [63:0] ch [3];
		logic [63:0] pk;
		colour_t res;
		res = '0;
		cx = longint'(c.chroma_x);
		cy = longint'(c.chroma_y);
		if (cy == 0)
			return res;
		cz = 65536 - cx - cy;
		lin[0] =  32404542 * cx - 15371385 * cy -  4985314 * cz;
		lin[1] =  -9692660 * cx + 18760108 * cy +   415560 * cz;
		lin[2] =    556434 * cx -  2040259 * cy + 10572252 * cz;
		for (int i = 0; i < 3; i++)
			ch[i] = (lin[i] > 0) ? 64'(lin[i]) : 64'd0;
		pk = ch[0];
		if (ch[1] > pk) pk = ch[1];
		if (ch[2] > pk) pk = ch[2];
		if (pk == 0)
			return res;
		res.red   = srgb_code(peak_ratio(ch[0], pk));
		res.green = srgb_code(peak_ratio(ch[1], pk));
		res.blue  = srgb_code(peak_ratio(ch[2], pk));
		return res;
	endfunction

	assign colours_pending = colour_due.size();

	always @(posedge clk or negedge arst_n) begin
		colour_t want;
		if (!arst_n) begin
			fail_count <= 0;
			colours_checked <= 0;
			colour_due.delete();
		end else begin
			if (done) begin
				if (colour_due.size() == 0) begin
					$error("colour %h with no request outstanding", colour);
					fail_count <= fail_count + 1;
				end else begin
					want = colour_due.pop_front();
					colours_checked <= colours_checked + 1;
					if (colour.red !== want.red ||
					    colour.green !== want.green ||
					    colour.blue !== want.blue)
						fail_count <= fail_count + 1;
					if (colour.red !== want.red)
						$error("red: expected %0d, got %0d", want.red, colour.red);
					if (colour.green !== want.green)
						$error("green: expected %0d, got %0d", want.green, colour.green);
					if (colour.blue !== want.blue)
						$error("blue: expected %0d, got %0d", want.blue, colour.blue);
				end
			end
			if (start && !busy)
				colour_due.push_back(predict_colour(chroma));
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the xy to srgb8 colour converter
// ----------------------------------------------------------------------------
// a directed set covers zero y, the coordinate extremes, x + y above one and
// the white point; then random requests, mostly inside the plausible
// chromaticity region, with random idle bursts. the checker alongside does
// all prediction.
// ----------------------------------------------------------------------------
module tb;
	import cxys8_pkg::*;

	localparam int RANDOM_REQS = 1530;
	localparam int CALM_TAIL   = 200;  // final requests sent back to back
	localparam int DRAIN_LAT   = 16 + RATIO_FRAC_BITS + 16;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	chroma_t chroma;
	logic    done;
	colour_t colour;

	int fail_count;
	int colours_pending;
	int colours_checked;
	int reqs_sent;
	int zero_y_reqs;

	chromaticity_xy_to_srgb8 DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.chroma (chroma),
		.done   (done),
		.colour (colour)
	);

	chroma_colour_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.chroma          (chroma),
		.done            (done),
		.colour          (colour),
		.fail_count      (fail_count),
		.colours_pending (colours_pending),
		.colours_checked (colours_checked)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// one request: raised at a falling edge, held until an edge with busy low
	task automatic send_request(input logic [15:0] cx, input logic [15:0] cy);
		@(negedge clk);
		start <= 1'b1;
		chroma <= '{chroma_x: cx, chroma_y: cy};
		do
			@(posedge clk);
		while (busy);
		reqs_sent++;
		if (cy == 16'd0)
			zero_y_reqs++;
	endtask

	task automatic idle_burst(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// generous ceiling, far beyond the slowest legal run
	initial begin
		#400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic [15:0] rx;
		logic [15:0] ry;
		int waited;
		start = 1'b0;
		chroma = '0;
		reqs_sent = 0;
		zero_y_reqs = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero y, whatever x is
		send_request(16'h0000, 16'h0000);
		send_request(16'hffff, 16'h0000);
		send_request(16'h5555, 16'h0000);
		// coordinate extremes, x + y at or well above one
		send_request(16'hffff, 16'hffff);
		send_request(16'h0000, 16'hffff);
		send_request(16'hffff, 16'h0001);
		send_request(16'h0000, 16'h0001);
		send_request(16'h0001, 16'h0001);
		send_request(16'h8000, 16'h8000);
		send_request(16'hc000, 16'h8000);
		// white point and the srgb primaries
		send_request(16'h500c, 16'h5438);
		send_request(16'ha3d7, 16'h547b);
		send_request(16'h4ccd, 16'h999a);
		send_request(16'h2666, 16'h0f5c);
		// spectral-locus corners, deep blue and far red
		send_request(16'h2b02, 16'h0120);
		send_request(16'hbc6a, 16'h4396);
		send_request(16'h1111, 16'hd999);
		// small ratios land on the linear segment
		send_request(16'h2800, 16'h0400);
		send_request(16'h0800, 16'h0800);
		send_request(16'h0200, 16'hfd00);
		send_request(16'hfd00, 16'h0200);

		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i < RANDOM_REQS - CALM_TAIL && $urandom_range(0, 3) == 0)
				idle_burst($urandom_range(1, 11));
			case ($urandom_range(0, 9))
				0, 1: begin
					// anything the fields allow
					rx = 16'($urandom);
					ry = 16'($urandom);
				end
				2: begin
					rx = 16'($urandom);
					ry = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom_range(1, 64));
				end
				default: begin
					// inside the triangle x, y >= 0, x + y <= 1
					rx = 16'($urandom_range(0, 52000));
					ry = 16'($urandom_range(1, 65535 - rx));
				end
			endcase
			send_request(rx, ry);
		end
		@(negedge clk);
		start <= 1'b0;

		while (colours_pending != 0)
			@(posedge clk);
		waited = 0;
		while (waited < DRAIN_LAT) begin
			@(posedge clk);
			waited++;
		end

		$display("%0d chromaticity requests sent, %0d of them with zero y", reqs_sent,
			zero_y_reqs);
		$display("%0d colours compared against prediction", colours_checked);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
